/* rtl/slxfp_pkg.sv */
`default_nettype none
package slxfp_pkg;

    // default bound on the payload length, sets the payload counter width
    localparam int unsigned MAX_PAYLOAD_BOUND_DEF = 512;

    // configuration port
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 10;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SYNC_FIRST    = 2'd0,
        CFG_SYNC_SECOND   = 2'd1,
        CFG_VERSION       = 2'd2,
        CFG_PAYLOAD_LIMIT = 2'd3
    } t_cfg_idx;

    localparam logic [7:0] SYNC_FIRST_RST    = 8'h42;
    localparam logic [7:0] SYNC_SECOND_RST   = 8'h46;
    localparam logic [7:0] VERSION_RST       = 8'h01;
    localparam logic [9:0] PAYLOAD_LIMIT_RST = 10'd512;

    // header byte positions after the sync pair
    localparam int unsigned HDR_IDX_W = 3;
    localparam logic [HDR_IDX_W-1:0] POS_VERSION = 3'd2;
    localparam logic [HDR_IDX_W-1:0] POS_TYPE    = 3'd3;
    localparam logic [HDR_IDX_W-1:0] POS_TAG     = 3'd4;
    localparam logic [HDR_IDX_W-1:0] POS_FLAGS   = 3'd5;
    localparam logic [HDR_IDX_W-1:0] POS_LEN_LO  = 3'd6;
    localparam logic [HDR_IDX_W-1:0] POS_LEN_HI  = 3'd7;

    typedef enum logic [1:0] {
        PH_HUNT,
        PH_SYNC,
        PH_HEAD,
        PH_BODY
    } t_phase;

    typedef enum logic [1:0] {
        KIND_PAYLOAD    = 2'd0,
        KIND_GOOD       = 2'd1,
        KIND_HEADER_ERR = 2'd2,
        KIND_CHECK_ERR  = 2'd3
    } t_kind;

endpackage
`default_nettype wire

/* rtl/slxfp_in_if.sv */
`default_nettype none
interface slxfp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface
`default_nettype wire

/* rtl/slxfp_out_if.sv */
`default_nettype none
interface slxfp_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] result_kind;
    logic [7:0] frame_kind;
    logic [7:0] request_tag;
    logic [7:0] data_byte;
    logic [9:0] data_count;

    modport source (output valid, output result_kind, output frame_kind,
                    output request_tag, output data_byte, output data_count,
                    input ready);
    modport sink   (input valid, input result_kind, input frame_kind,
                    input request_tag, input data_byte, input data_count,
                    output ready);
endinterface
`default_nettype wire

/* rtl/sync_length_xor_frame_parser.sv */
`default_nettype none
// Byte-serial frame deframer. Each input beat carries one link byte. The parser
// hunts for the sync pair (sync_first then sync_second; a broken pair whose
// second byte is sync_first counts as a fresh first sync byte), then reads
// version, type, request id, flags and a little-endian 16-bit length. A wrong
// version or a length above min(payload_limit, MAX_PAYLOAD_BOUND) gives one
// header-error beat on the high length byte and the hunt restarts. Otherwise
// every payload byte leaves as a payload beat as soon as it arrives, and the
// byte after the payload is the XOR check over all bytes after the sync pair;
// it yields one good or checksum-error beat carrying the payload length. On a
// checksum error the consumer must drop the payload beats it already took.
// Throughput is one byte per clock while the consumer takes results: the byte
// is registered, decoded by a single pass of compare/XOR logic and the result
// is registered on the output side. The input register can still take a byte
// while a result waits if it is empty, so only a stalled consumer with both
// registers full holds the input off. Bytes that cause no result produce no
// output beat. Configuration writes go on the plain write port and must only
// happen while the parser is idle.
module sync_length_xor_frame_parser #(
    parameter int unsigned MAX_PAYLOAD_BOUND = slxfp_pkg::MAX_PAYLOAD_BOUND_DEF
) (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire                                i_cfg_we,
    input  wire [slxfp_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  wire [slxfp_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    slxfp_in_if.sink                           i_rx,
    slxfp_out_if.source                        o_res
);
    import slxfp_pkg::*;

    // payload counter must hold the bound itself
    localparam int unsigned CNT_W = $clog2(MAX_PAYLOAD_BOUND + 1);
    localparam logic [16:0] BOUND = 17'(MAX_PAYLOAD_BOUND);

    // configuration registers
    logic [7:0] r_sync_first;
    logic [7:0] r_sync_second;
    logic [7:0] r_version;
    logic [9:0] r_limit;

    // input register
    logic       r_in_vld;
    logic [7:0] r_in_byte;

    // parser state
    t_phase               r_phase, n_phase;
    logic [HDR_IDX_W-1:0] r_hidx, n_hidx;
    logic [7:0]           r_len_lo, n_len_lo;
    logic [CNT_W-1:0]     r_pay_len, n_pay_len;
    logic [CNT_W-1:0]     r_pay_cnt, n_pay_cnt;
    logic [7:0]           r_check, n_check;
    logic [7:0]           r_kind, n_kind;
    logic [7:0]           r_tag, n_tag;
    logic                 r_vgood, n_vgood;

    // result register
    logic       r_out_vld;
    logic [1:0] r_out_kind;
    logic [7:0] r_out_fkind;
    logic [7:0] r_out_tag;
    logic [7:0] r_out_data;
    logic [9:0] r_out_count;

    // decode of the registered byte
    logic        emit;
    t_kind       res_kind;
    logic [7:0]  res_data;
    logic [9:0]  res_count;
    logic [15:0] len;
    logic [16:0] eff_limit;
    logic        len_over;
    logic        advance;

    // the decode stage moves on when the result register is free or drains
    assign advance    = !r_out_vld || o_res.ready;
    assign i_rx.ready = !r_in_vld || advance;

    assign len       = {r_in_byte, r_len_lo};
    // payload_limit saturated at the elaboration bound
    assign eff_limit = ({7'd0, r_limit} > BOUND) ? BOUND : {7'd0, r_limit};
    assign len_over  = {1'b0, len} > eff_limit;

    // config writes, reset to the protocol defaults
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sync_first  <= SYNC_FIRST_RST;
            r_sync_second <= SYNC_SECOND_RST;
            r_version     <= VERSION_RST;
            r_limit       <= PAYLOAD_LIMIT_RST;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_SYNC_FIRST:    r_sync_first  <= i_cfg_data[7:0];
                CFG_SYNC_SECOND:   r_sync_second <= i_cfg_data[7:0];
                CFG_VERSION:       r_version     <= i_cfg_data[7:0];
                CFG_PAYLOAD_LIMIT: r_limit       <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // next-state logic, evaluated on the byte in the input register
    always_comb begin
        n_phase   = r_phase;
        n_hidx    = r_hidx;
        n_len_lo  = r_len_lo;
        n_pay_len = r_pay_len;
        n_pay_cnt = r_pay_cnt;
        n_check   = r_check;
        n_kind    = r_kind;
        n_tag     = r_tag;
        n_vgood   = r_vgood;
        case (r_phase)
            PH_HUNT: begin
                if (r_in_byte == r_sync_first) n_phase = PH_SYNC;
            end
            PH_SYNC: begin
                if (r_in_byte != r_sync_second) begin
                    // broken pair: a repeated first sync byte keeps the hunt one step on
                    n_phase = (r_in_byte == r_sync_first) ? PH_SYNC : PH_HUNT;
                end else begin
                    n_check = 8'd0;
                    n_hidx  = POS_VERSION;
                    n_phase = PH_HEAD;
                end
            end
            PH_HEAD: begin
                n_check = r_check ^ r_in_byte;
                n_hidx  = r_hidx + 1'b1;
                case (r_hidx)
                    POS_VERSION: n_vgood  = (r_in_byte == r_version);
                    POS_TYPE:    n_kind   = r_in_byte;
                    POS_TAG:     n_tag    = r_in_byte;
                    POS_FLAGS:   ;
                    POS_LEN_LO:  n_len_lo = r_in_byte;
                    POS_LEN_HI: begin
                        if (!r_vgood || len_over) begin
                            n_phase   = PH_HUNT;
                            n_pay_len = '0;
                        end else begin
                            n_pay_len = CNT_W'(len);
                            n_pay_cnt = '0;
                            n_phase   = PH_BODY;
                        end
                    end
                    default: ;
                endcase
            end
            PH_BODY: begin
                if (r_pay_cnt < r_pay_len) begin
                    n_check   = r_check ^ r_in_byte;
                    n_pay_cnt = r_pay_cnt + 1'b1;
                end else begin
                    n_phase = PH_HUNT;
                end
            end
            default: n_phase = PH_HUNT;
        endcase
    end

    // result decode for the same byte
    always_comb begin
        emit      = 1'b0;
        res_kind  = KIND_PAYLOAD;
        res_data  = 8'd0;
        res_count = 10'd0;
        case (r_phase)
            PH_HEAD: begin
                if (r_hidx == POS_LEN_HI && (!r_vgood || len_over)) begin
                    emit     = 1'b1;
                    res_kind = KIND_HEADER_ERR;
                end
            end
            PH_BODY: begin
                emit = 1'b1;
                if (r_pay_cnt < r_pay_len) begin
                    res_data = r_in_byte;
                end else begin
                    // check byte closes the frame
                    res_kind  = (r_in_byte == r_check) ? KIND_GOOD : KIND_CHECK_ERR;
                    res_count = 10'(r_pay_len);
                end
            end
            default: ;
        endcase
    end

    // input register and parser state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_phase   <= PH_HUNT;
            r_hidx    <= '0;
            r_len_lo  <= 8'd0;
            r_pay_len <= '0;
            r_pay_cnt <= '0;
            r_check   <= 8'd0;
            r_kind    <= 8'd0;
            r_tag     <= 8'd0;
            r_vgood   <= 1'b0;
        end else begin
            if (i_rx.ready) r_in_vld <= i_rx.valid;
            if (r_in_vld && advance) begin
                r_phase   <= n_phase;
                r_hidx    <= n_hidx;
                r_len_lo  <= n_len_lo;
                r_pay_len <= n_pay_len;
                r_pay_cnt <= n_pay_cnt;
                r_check   <= n_check;
                r_kind    <= n_kind;
                r_tag     <= n_tag;
                r_vgood   <= n_vgood;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rx.ready && i_rx.valid) r_in_byte <= i_rx.rx_byte;
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (advance) begin
            r_out_vld <= r_in_vld && emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && r_in_vld && emit) begin
            r_out_kind  <= res_kind;
            r_out_fkind <= n_kind;
            r_out_tag   <= n_tag;
            r_out_data  <= res_data;
            r_out_count <= res_count;
        end
    end

    assign o_res.valid       = r_out_vld;
    assign o_res.result_kind = r_out_kind;
    assign o_res.frame_kind  = r_out_fkind;
    assign o_res.request_tag = r_out_tag;
    assign o_res.data_byte   = r_out_data;
    assign o_res.data_count  = r_out_count;

endmodule
`default_nettype wire
